>>> src/hdms_pkg.sv
package hdms_pkg;

    localparam int DIST_W     = 24;
    localparam int ACC_W      = 40;
    localparam int COEF_W     = 16;
    localparam int IDX_W      = 7;
    localparam int DIM_W      = 7;
    localparam int SQ_W       = 56;  // radicand: norm squared shifted up by 16
    localparam int ROOT_W     = 28;
    localparam int MAG_W      = 40;
    localparam int REM_W      = 52;  // root shifted up by the quotient width
    localparam int SQRT_STEPS = 28;
    localparam int DIV_STEPS  = 24;
    localparam int STEP_W     = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_COORD = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_BRD  = 8'b0000_1000,
        ST_SQRT = 8'b0001_0000,
        ST_DIVI = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load_coef;
        logic take_coord;
        logic mul;
        logic acc;
        logic b_read;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic finish;
        logic sqrt_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

>>> src/hdms_ctrl.sv
module hdms_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              req_type,
    output logic              s_tready,
    input  hdms_pkg::status_t status,
    output hdms_pkg::cmd_t    cmd
);

    hdms_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hdms_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == hdms_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            hdms_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (req_type == hdms_pkg::REQ_COORD) begin
                        cmd.take_coord = 1'b1;
                        state_next     = hdms_pkg::ST_MUL;
                    end else begin
                        cmd.load_coef = 1'b1;
                    end
                end
            end
            hdms_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = hdms_pkg::ST_ACC;
            end
            hdms_pkg::ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = status.finish ? hdms_pkg::ST_BRD : hdms_pkg::ST_IDLE;
            end
            hdms_pkg::ST_BRD: begin
                cmd.b_read = 1'b1;
                state_next = hdms_pkg::ST_SQRT;
            end
            hdms_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last) begin
                    state_next = hdms_pkg::ST_DIVI;
                end
            end
            hdms_pkg::ST_DIVI: begin
                cmd.div_init = 1'b1;
                state_next   = hdms_pkg::ST_DIV;
            end
            hdms_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = hdms_pkg::ST_OUT;
                end
            end
            hdms_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = hdms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hdms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/hdms_dp.sv
module hdms_dp #(
    parameter int MAX_DIM = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hdms_pkg::DIM_W-1:0]    cfg_wr_data,
    input  logic [hdms_pkg::IDX_W-1:0]    coef_index,
    input  logic signed [hdms_pkg::COEF_W-1:0] value,
    input  logic                          last_point,
    input  hdms_pkg::cmd_t                cmd,
    output hdms_pkg::status_t             status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hdms_pkg::DIST_W-1:0]   point_distance,
    output logic [hdms_pkg::DIST_W-1:0]   min_distance,
    output logic                          set_done
);

    localparam int AW = $clog2(MAX_DIM + 1);
    localparam int ACC_W = hdms_pkg::ACC_W;

    logic signed [hdms_pkg::COEF_W-1:0] coef_mem [MAX_DIM+1];
    logic signed [hdms_pkg::COEF_W-1:0] rd_data_reg;
    logic signed [hdms_pkg::COEF_W-1:0] v_reg;
    logic                               last_reg;
    logic [hdms_pkg::DIM_W-1:0]         dim_reg;
    logic [AW-1:0]                      dim_use;
    logic [AW-1:0]                      count_reg;
    logic [AW-1:0]                      count_inc;
    logic [AW-1:0]                      rd_addr;

    logic signed [31:0]      prod_dot_reg;
    logic signed [31:0]      prod_sq_reg;
    logic signed [ACC_W-1:0] dot_reg;
    logic [ACC_W-1:0]        norm_reg;
    logic signed [ACC_W:0]   dot_sum;
    logic [ACC_W:0]          norm_sum;

    logic signed [ACC_W:0]          ip_reg;
    logic [hdms_pkg::MAG_W-1:0]     mag;
    logic [hdms_pkg::SQ_W-1:0]      x_reg, r_reg, bit_reg, rb;
    logic [hdms_pkg::REM_W-1:0]     rem_reg, dsh_reg, num_ext, den_top;
    logic [hdms_pkg::DIST_W-1:0]    quo_reg;
    logic                           sat_reg;
    logic                           zero_reg;
    logic [hdms_pkg::STEP_W-1:0]    step_reg;
    logic [hdms_pkg::DIST_W-1:0]    dist_val;
    logic [hdms_pkg::DIST_W-1:0]    new_min;
    logic [hdms_pkg::DIST_W-1:0]    run_min_reg;
    logic                           min_valid_reg;
    logic                           m_valid_reg;
    logic [hdms_pkg::DIST_W-1:0]    pd_reg, md_reg;
    logic                           done_reg;

    // clamp the dimension to 1..MAX_DIM
    always_comb begin
        if (dim_reg == '0) begin
            dim_use = AW'(1);
        end else if (32'(dim_reg) > MAX_DIM) begin
            dim_use = AW'(MAX_DIM);
        end else begin
            dim_use = AW'(dim_reg);
        end
    end

    assign count_inc = count_reg + AW'(1);
    assign rd_addr   = cmd.b_read ? dim_use : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= hdms_pkg::DIM_W'(1);
        end else if (cfg_wr_en) begin
            dim_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_coef && (32'(coef_index) <= MAX_DIM)) begin
            coef_mem[AW'(coef_index)] <= value;
        end
        if (cmd.take_coord || cmd.b_read) begin
            rd_data_reg <= coef_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_coord) begin
            v_reg    <= value;
            last_reg <= last_point;
        end
        if (cmd.mul) begin
            prod_dot_reg <= 32'(rd_data_reg) * 32'(v_reg);
            prod_sq_reg  <= 32'(rd_data_reg) * 32'(rd_data_reg);
        end
    end

    assign dot_sum  = (ACC_W+1)'(dot_reg) + (ACC_W+1)'(prod_dot_reg);
    assign norm_sum = {1'b0, norm_reg} + (ACC_W+1)'(unsigned'(prod_sq_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg   <= '0;
            norm_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.acc) begin
            if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
                dot_reg <= dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                dot_reg <= dot_sum[ACC_W-1:0];
            end
            norm_reg  <= norm_sum[ACC_W] ? '1 : norm_sum[ACC_W-1:0];
            count_reg <= count_inc;
        end else if (cmd.emit) begin
            dot_reg   <= '0;
            norm_reg  <= '0;
            count_reg <= '0;
        end
    end

    // square root, one result bit per step
    assign rb = r_reg + bit_reg;
    assign mag = ip_reg[ACC_W] ? hdms_pkg::MAG_W'(-ip_reg) : hdms_pkg::MAG_W'(ip_reg);
    assign num_ext = {2'b00, mag, 10'b0};
    assign den_top = {r_reg[hdms_pkg::ROOT_W-1:0], 24'b0};

    always_ff @(posedge aclk) begin
        if (cmd.b_read) begin
            x_reg    <= {norm_reg, 16'b0};
            r_reg    <= '0;
            bit_reg  <= hdms_pkg::SQ_W'(1) << (hdms_pkg::SQ_W - 2);
            step_reg <= '0;
            zero_reg <= (norm_reg == '0);
        end else if (cmd.sqrt_step) begin
            ip_reg <= (ACC_W+1)'(dot_reg) + ((ACC_W+1)'(rd_data_reg) <<< 14);
            if (x_reg >= rb) begin
                x_reg <= x_reg - rb;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg + hdms_pkg::STEP_W'(1);
        end else if (cmd.div_init) begin
            rem_reg  <= num_ext;
            dsh_reg  <= hdms_pkg::REM_W'(r_reg[hdms_pkg::ROOT_W-1:0]) << 23;
            sat_reg  <= (num_ext >= den_top);
            quo_reg  <= '0;
            step_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[hdms_pkg::DIST_W-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[hdms_pkg::DIST_W-2:0], 1'b0};
            end
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg + hdms_pkg::STEP_W'(1);
        end
    end

    assign status = '{
        finish:    (count_inc >= dim_use),
        sqrt_last: (step_reg == hdms_pkg::STEP_W'(hdms_pkg::SQRT_STEPS - 1)),
        div_last:  (step_reg == hdms_pkg::STEP_W'(hdms_pkg::DIV_STEPS - 1)),
        out_free:  (!m_valid_reg || m_tready)
    };

    assign dist_val = (zero_reg || sat_reg) ? hdms_pkg::DIST_MAX : quo_reg;
    assign new_min  = (!min_valid_reg || dist_val < run_min_reg) ? dist_val : run_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_min_reg   <= hdms_pkg::DIST_MAX;
            min_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
                pd_reg      <= dist_val;
                md_reg      <= new_min;
                done_reg    <= last_reg;
                if (last_reg) begin
                    run_min_reg   <= hdms_pkg::DIST_MAX;
                    min_valid_reg <= 1'b0;
                end else begin
                    run_min_reg   <= new_min;
                    min_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign point_distance = pd_reg;
    assign min_distance   = md_reg;
    assign set_done       = done_reg;

endmodule

>>> src/hyperplane_distance_min_scan.sv
// Channel  | Ports                          | Contents
// ---------+--------------------------------+--------------------------------------------
// input    | s_tvalid/s_tready/s_tdata/...  | tdata: coef_index, value; tuser: req_type;
//          |                                | tlast: last_point
// result   | m_tvalid/m_tready/m_tdata/...  | tdata: point_distance, min_distance;
//          |                                | tlast: set_done
// config   | cfg_wr_en/cfg_wr_data          | dimension
//
// A coefficient load is written in the idle state. A coordinate passes read, multiply and
// accumulate; the coordinate that finishes a point then passes coefficient
// read, 28 steps of the bit-serial square root, divider setup, 24 steps of the
// restoring divider and the output load. The root and the divider share one step counter.
// Reset (aresetn low, synchronous) clears accumulators, count, minimum and dimension 1.
// A stalled result holds in the output register while the next items are taken.
module hyperplane_distance_min_scan #(
    parameter int MAX_DIM = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // dimension
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [6:0] coef_index, [22:7] value, [23] unused
    input  logic [0:0]  s_tuser,       // [0] req_type
    input  logic        s_tlast,       // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // [23:0] point_distance, [47:24] min_distance
    output logic        m_tlast        // set_done
);

    hdms_pkg::cmd_t    cmd;
    hdms_pkg::status_t status;

    // sequencer: walks each coordinate through multiply and accumulate, the last of a point through root and divide
    hdms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // coefficient memory, accumulators, root/divide units and output register
    hdms_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .coef_index     (s_tdata[6:0]),
        .value          (s_tdata[22:7]),
        .last_point     (s_tlast),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .point_distance (m_tdata[23:0]),
        .min_distance   (m_tdata[47:24]),
        .set_done       (m_tlast)
    );

endmodule

>>> src/hdms_checker.sv
module hdms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // running minimum never exceeds the point that produced it
    a_min_le_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:24] <= m_tdata[23:0])
        else $error("minimum above point distance");

    // no result in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind hyperplane_distance_min_scan hdms_checker u_hdms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
